[src/msqrt_pkg.sv]
// shared types, constants and helpers for the modular square root block
package msqrt_pkg;

  localparam int unsigned WIDTH = 32;
  localparam int unsigned VAL_W = WIDTH;
  localparam int unsigned MOD_W = WIDTH - 1;
  localparam int unsigned EXP_W = WIDTH - 2;
  localparam int unsigned BI_W  = $clog2(EXP_W);
  localparam int unsigned CNT_W = $clog2(VAL_W);
  localparam int unsigned K_W   = $clog2(2 * WIDTH);
  localparam int unsigned KH_W  = K_W - 1;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic [MOD_W-1:0]        modulus;
  } in_t;

  typedef struct packed {
    logic [MOD_W-1:0] root;
    logic             failed;
  } out_t;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_LOAD,
    OP_MUL,
    OP_FIXN,
    OP_POW_INIT,
    OP_FIND_INIT,
    OP_BI_DEC,
    OP_TOP_SET,
    OP_K_INIT,
    OP_K_NEXT,
    OP_XC_DBL,
    OP_CC_SUM,
    OP_T_XC,
    OP_XC_SUMK,
    OP_OUT_N,
    OP_OUT_U,
    OP_OUT_F
  } op_e;

  typedef enum logic [2:0] {
    SRC_XC,
    SRC_CC,
    SRC_T,
    SRC_U,
    SRC_N,
    SRC_KK,
    SRC_ONE,
    SRC_MAG
  } src_e;

  typedef enum logic {
    DST_T,
    DST_U
  } dst_e;

  typedef struct packed {
    op_e  op;
    src_e a_sel;
    src_e b_sel;
    dst_e dst;
  } cmd_t;

  typedef struct packed {
    logic p_zero;
    logic p_two;
    logic p_mod3;
    logic n_zero;
    logic e_bit;
    logic half_bit;
    logic bi_zero;
    logic k_ok;
    logic cc_zero;
    logic t_eq_n;
    logic mul_done;
  } status_t;

  function automatic logic [MOD_W-1:0] add_mod(input logic [MOD_W-1:0] a,
                                               input logic [MOD_W-1:0] b,
                                               input logic [MOD_W-1:0] p);
    logic [MOD_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, p}) begin
      s = s - {1'b0, p};
    end
    return s[MOD_W-1:0];
  endfunction

endpackage

[src/msqrt_mulmod.sv]
// bit-serial modular multiplier, one multiplier bit per cycle
module msqrt_mulmod (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [msqrt_pkg::MOD_W-1:0]    a_i,
  input  logic [msqrt_pkg::VAL_W-1:0]    b_i,
  input  logic [msqrt_pkg::MOD_W-1:0]    p_i,
  output logic                           done_o,
  output logic [msqrt_pkg::MOD_W-1:0]    r_o
);

  logic [msqrt_pkg::MOD_W-1:0] a_q, a_d;
  logic [msqrt_pkg::VAL_W-1:0] b_q, b_d;
  logic [msqrt_pkg::MOD_W-1:0] r_q, r_d;
  logic [msqrt_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic                        act_q, act_d;
  logic                        done_q, done_d;
  logic [msqrt_pkg::MOD_W-1:0] dbl;

  always_comb begin
    a_d    = a_q;
    b_d    = b_q;
    r_d    = r_q;
    cnt_d  = cnt_q;
    act_d  = act_q;
    done_d = 1'b0;
    dbl    = msqrt_pkg::add_mod(r_q, r_q, p_i);
    if (start_i) begin
      a_d   = a_i;
      b_d   = b_i;
      r_d   = '0;
      cnt_d = msqrt_pkg::CNT_W'(msqrt_pkg::VAL_W - 1);
      act_d = 1'b1;
    end else if (act_q) begin
      r_d = b_q[cnt_q] ? msqrt_pkg::add_mod(dbl, a_q, p_i) : dbl;
      if (cnt_q == '0) begin
        act_d  = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      act_q  <= act_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
    r_q <= r_d;
  end

  assign done_o = done_q;
  assign r_o    = r_q;

endmodule

[src/msqrt_datapath.sv]
// operand registers, counters and result register of the root search
module msqrt_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  msqrt_pkg::in_t     in_i,
  input  msqrt_pkg::cmd_t    cmd_i,
  output msqrt_pkg::status_t status_o,
  output msqrt_pkg::out_t    result_o,
  output logic               valid_o
);

  localparam int unsigned MW = msqrt_pkg::MOD_W;

  logic [MW-1:0]                 p_q, p_d, n_q, n_d, xc_q, xc_d, cc_q, cc_d;
  logic [MW-1:0]                 t_q, t_d, u_q, u_d, kk_q, kk_d;
  logic [msqrt_pkg::VAL_W-1:0]   mag_q, mag_d, vu;
  logic                          neg_q, neg_d;
  logic [msqrt_pkg::K_W-1:0]     k_q, k_d;
  logic [msqrt_pkg::BI_W-1:0]    bi_q, bi_d, top_q, top_d;
  msqrt_pkg::dst_e               dst_q, dst_d;
  msqrt_pkg::out_t               out_q, out_d;
  logic                          valid_q, valid_d;
  logic [MW-1:0]                 mul_a, mul_r, pm1;
  logic [msqrt_pkg::VAL_W-1:0]   mul_b;
  logic                          mul_done, mul_start;
  logic [msqrt_pkg::EXP_W-1:0]   e, half;
  logic [msqrt_pkg::KH_W-1:0]    kh;
  logic [MW:0]                   kk_inc;

  msqrt_mulmod u_mulmod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mul_start),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .p_i    (p_q),
    .done_o (mul_done),
    .r_o    (mul_r)
  );

  assign mul_start = (cmd_i.op == msqrt_pkg::OP_MUL);
  assign vu        = in_i.value;
  assign e         = msqrt_pkg::EXP_W'(p_q[MW-1:2]) + 1'b1;
  assign pm1       = p_q - 1'b1;
  assign half      = pm1[MW-1:1];
  assign kh        = k_q[msqrt_pkg::K_W-1:1];
  assign kk_inc    = {1'b0, kk_q} + 1'b1;

  always_comb begin
    case (cmd_i.a_sel)
      msqrt_pkg::SRC_XC:  mul_a = xc_q;
      msqrt_pkg::SRC_CC:  mul_a = cc_q;
      msqrt_pkg::SRC_T:   mul_a = t_q;
      msqrt_pkg::SRC_U:   mul_a = u_q;
      msqrt_pkg::SRC_N:   mul_a = n_q;
      msqrt_pkg::SRC_KK:  mul_a = kk_q;
      default:            mul_a = MW'(1);
    endcase
    case (cmd_i.b_sel)
      msqrt_pkg::SRC_XC:  mul_b = {1'b0, xc_q};
      msqrt_pkg::SRC_CC:  mul_b = {1'b0, cc_q};
      msqrt_pkg::SRC_T:   mul_b = {1'b0, t_q};
      msqrt_pkg::SRC_U:   mul_b = {1'b0, u_q};
      msqrt_pkg::SRC_N:   mul_b = {1'b0, n_q};
      msqrt_pkg::SRC_KK:  mul_b = {1'b0, kk_q};
      msqrt_pkg::SRC_ONE: mul_b = msqrt_pkg::VAL_W'(1);
      default:            mul_b = mag_q;
    endcase
  end

  always_comb begin
    p_d = p_q; n_d = n_q; xc_d = xc_q; cc_d = cc_q; t_d = t_q; u_d = u_q;
    kk_d = kk_q; mag_d = mag_q; neg_d = neg_q; k_d = k_q; bi_d = bi_q;
    top_d = top_q; dst_d = dst_q; out_d = out_q; valid_d = 1'b0;
    if (mul_done) begin
      if (dst_q == msqrt_pkg::DST_T) begin
        t_d = mul_r;
      end else begin
        u_d = mul_r;
      end
    end
    unique case (cmd_i.op)
      msqrt_pkg::OP_LOAD: begin
        p_d   = in_i.modulus;
        neg_d = vu[msqrt_pkg::VAL_W-1];
        mag_d = vu[msqrt_pkg::VAL_W-1] ? (~vu + 1'b1) : vu;
        k_d   = msqrt_pkg::K_W'(1);
        kk_d  = MW'(1);
      end
      msqrt_pkg::OP_MUL:       dst_d = cmd_i.dst;
      msqrt_pkg::OP_FIXN:      n_d = (neg_q && t_q != '0) ? (p_q - t_q) : t_q;
      msqrt_pkg::OP_POW_INIT: begin
        u_d  = MW'(1);
        bi_d = msqrt_pkg::BI_W'(msqrt_pkg::EXP_W - 1);
      end
      msqrt_pkg::OP_FIND_INIT: bi_d = msqrt_pkg::BI_W'(msqrt_pkg::EXP_W - 1);
      msqrt_pkg::OP_BI_DEC:    bi_d = bi_q - 1'b1;
      msqrt_pkg::OP_TOP_SET:   top_d = bi_q;
      msqrt_pkg::OP_K_INIT: begin
        xc_d = MW'(1);
        cc_d = kk_q;
        bi_d = top_q;
      end
      msqrt_pkg::OP_K_NEXT: begin
        k_d  = k_q + 1'b1;
        kk_d = (kk_inc == {1'b0, p_q}) ? '0 : kk_inc[MW-1:0];
      end
      msqrt_pkg::OP_XC_DBL:  xc_d = msqrt_pkg::add_mod(u_q, u_q, p_q);
      msqrt_pkg::OP_CC_SUM:  cc_d = msqrt_pkg::add_mod(u_q, t_q, p_q);
      msqrt_pkg::OP_T_XC:    t_d = xc_q;
      msqrt_pkg::OP_XC_SUMK: xc_d = msqrt_pkg::add_mod(cc_q, u_q, p_q);
      msqrt_pkg::OP_OUT_N: begin
        out_d.root = n_q; out_d.failed = 1'b0; valid_d = 1'b1;
      end
      msqrt_pkg::OP_OUT_U: begin
        out_d.root = u_q; out_d.failed = 1'b0; valid_d = 1'b1;
      end
      msqrt_pkg::OP_OUT_F: begin
        out_d.root = '0; out_d.failed = 1'b1; valid_d = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      k_q     <= '0;
      bi_q    <= '0;
      top_q   <= '0;
      dst_q   <= msqrt_pkg::DST_T;
    end else begin
      valid_q <= valid_d;
      k_q     <= k_d;
      bi_q    <= bi_d;
      top_q   <= top_d;
      dst_q   <= dst_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q <= p_d; n_q <= n_d; xc_q <= xc_d; cc_q <= cc_d; t_q <= t_d; u_q <= u_d;
    kk_q <= kk_d; mag_q <= mag_d; neg_q <= neg_d; out_q <= out_d;
  end

  always_comb begin
    status_o.p_zero   = (p_q == '0);
    status_o.p_two    = (p_q == MW'(2));
    status_o.p_mod3   = (p_q[1:0] == 2'b11);
    status_o.n_zero   = (n_q == '0);
    status_o.e_bit    = e[bi_q];
    status_o.half_bit = half[bi_q];
    status_o.bi_zero  = (bi_q == '0);
    status_o.k_ok     = (kh < msqrt_pkg::KH_W'(MW)) &&
                        ((msqrt_pkg::VAL_W'(1) << kh) < {1'b0, p_q});
    status_o.cc_zero  = (cc_q == '0);
    status_o.t_eq_n   = (t_q == n_q);
    status_o.mul_done = mul_done;
  end

  assign result_o = out_q;
  assign valid_o  = valid_q;

endmodule

[src/msqrt_ctrl.sv]
// sequencer that steps the datapath through reduction, power and search
module msqrt_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  msqrt_pkg::status_t status_i,
  output msqrt_pkg::cmd_t    cmd_o,
  output logic               busy
);

  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_CHK0  = 5'd1;
  localparam logic [4:0] ST_MODN  = 5'd2;
  localparam logic [4:0] ST_FIXN  = 5'd3;
  localparam logic [4:0] ST_CHK1  = 5'd4;
  localparam logic [4:0] ST_PSQ   = 5'd5;
  localparam logic [4:0] ST_PMUL  = 5'd6;
  localparam logic [4:0] ST_PNEXT = 5'd7;
  localparam logic [4:0] ST_FIND  = 5'd8;
  localparam logic [4:0] ST_KCHK  = 5'd9;
  localparam logic [4:0] ST_BTEST = 5'd10;
  localparam logic [4:0] ST_S1    = 5'd11;
  localparam logic [4:0] ST_S2    = 5'd12;
  localparam logic [4:0] ST_S3    = 5'd13;
  localparam logic [4:0] ST_S4    = 5'd14;
  localparam logic [4:0] ST_S5    = 5'd15;
  localparam logic [4:0] ST_S6    = 5'd16;
  localparam logic [4:0] ST_B1    = 5'd17;
  localparam logic [4:0] ST_B2    = 5'd18;
  localparam logic [4:0] ST_B3    = 5'd19;
  localparam logic [4:0] ST_B4    = 5'd20;
  localparam logic [4:0] ST_B5    = 5'd21;
  localparam logic [4:0] ST_B6    = 5'd22;
  localparam logic [4:0] ST_C0    = 5'd23;
  localparam logic [4:0] ST_R1    = 5'd24;
  localparam logic [4:0] ST_R2    = 5'd25;
  localparam logic [4:0] ST_R3    = 5'd26;
  localparam logic [4:0] ST_OUTN  = 5'd27;
  localparam logic [4:0] ST_OUTU  = 5'd28;
  localparam logic [4:0] ST_OUTF  = 5'd29;

  logic [4:0] state_q, state_d;
  logic       issued_q, issued_d;
  logic       mul_req;

  always_comb begin
    state_d     = state_q;
    mul_req     = 1'b0;
    cmd_o.op    = msqrt_pkg::OP_NOP;
    cmd_o.a_sel = msqrt_pkg::SRC_XC;
    cmd_o.b_sel = msqrt_pkg::SRC_XC;
    cmd_o.dst   = msqrt_pkg::DST_T;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.op = msqrt_pkg::OP_LOAD;
          state_d  = ST_CHK0;
        end
      end
      ST_CHK0: state_d = status_i.p_zero ? ST_OUTF : ST_MODN;
      ST_MODN: begin
        mul_req = 1'b1;
        cmd_o.a_sel = msqrt_pkg::SRC_ONE; cmd_o.b_sel = msqrt_pkg::SRC_MAG;
        if (status_i.mul_done) state_d = ST_FIXN;
      end
      ST_FIXN: begin
        cmd_o.op = msqrt_pkg::OP_FIXN;
        state_d  = ST_CHK1;
      end
      ST_CHK1: begin
        if (status_i.p_two || status_i.n_zero) begin
          state_d = ST_OUTN;
        end else if (status_i.p_mod3) begin
          cmd_o.op = msqrt_pkg::OP_POW_INIT;
          state_d  = ST_PSQ;
        end else begin
          cmd_o.op = msqrt_pkg::OP_FIND_INIT;
          state_d  = ST_FIND;
        end
      end
      ST_PSQ: begin
        mul_req = 1'b1;
        cmd_o.a_sel = msqrt_pkg::SRC_U; cmd_o.b_sel = msqrt_pkg::SRC_U;
        cmd_o.dst = msqrt_pkg::DST_U;
        if (status_i.mul_done) state_d = status_i.e_bit ? ST_PMUL : ST_PNEXT;
      end
      ST_PMUL: begin
        mul_req = 1'b1;
        cmd_o.a_sel = msqrt_pkg::SRC_U; cmd_o.b_sel = msqrt_pkg::SRC_N;
        cmd_o.dst = msqrt_pkg::DST_U;
        if (status_i.mul_done) state_d = ST_PNEXT;
      end
      ST_PNEXT: begin
        if (status_i.bi_zero) begin
          state_d = ST_OUTU;
        end else begin
          cmd_o.op = msqrt_pkg::OP_BI_DEC;
          state_d  = ST_PSQ;
        end
      end
      ST_FIND: begin
        if (status_i.half_bit || status_i.bi_zero) begin
          cmd_o.op = msqrt_pkg::OP_TOP_SET;
          state_d  = ST_KCHK;
        end else begin
          cmd_o.op = msqrt_pkg::OP_BI_DEC;
        end
      end
      ST_KCHK: begin
        if (status_i.k_ok) begin
          cmd_o.op = msqrt_pkg::OP_K_INIT;
          state_d  = ST_BTEST;
        end else begin
          state_d = ST_OUTF;
        end
      end
      ST_BTEST: begin
        if (status_i.bi_zero) begin
          cmd_o.op = msqrt_pkg::OP_K_NEXT;
          state_d  = ST_KCHK;
        end else begin
          cmd_o.op = msqrt_pkg::OP_BI_DEC;
          state_d  = ST_S1;
        end
      end
      ST_S1: begin
        mul_req = 1'b1;
        cmd_o.a_sel = msqrt_pkg::SRC_XC; cmd_o.b_sel = msqrt_pkg::SRC_XC;
        cmd_o.dst = msqrt_pkg::DST_T;
        if (status_i.mul_done) state_d = ST_S2;
      end
      ST_S2: begin
        mul_req = 1'b1;
        cmd_o.a_sel = msqrt_pkg::SRC_XC; cmd_o.b_sel = msqrt_pkg::SRC_CC;
        cmd_o.dst = msqrt_pkg::DST_U;
        if (status_i.mul_done) state_d = ST_S3;
      end
      ST_S3: begin
        cmd_o.op = msqrt_pkg::OP_XC_DBL;
        state_d  = ST_S4;
      end
      ST_S4: begin
        mul_req = 1'b1;
        cmd_o.a_sel = msqrt_pkg::SRC_CC; cmd_o.b_sel = msqrt_pkg::SRC_CC;
        cmd_o.dst = msqrt_pkg::DST_U;
        if (status_i.mul_done) state_d = ST_S5;
      end
      ST_S5: begin
        mul_req = 1'b1;
        cmd_o.a_sel = msqrt_pkg::SRC_T; cmd_o.b_sel = msqrt_pkg::SRC_N;
        cmd_o.dst = msqrt_pkg::DST_T;
        if (status_i.mul_done) state_d = ST_S6;
      end
      ST_S6: begin
        cmd_o.op = msqrt_pkg::OP_CC_SUM;
        state_d  = status_i.half_bit ? ST_B1 : ST_C0;
      end
      ST_B1: begin
        cmd_o.op = msqrt_pkg::OP_T_XC;
        state_d  = ST_B2;
      end
      ST_B2: begin
        mul_req = 1'b1;
        cmd_o.a_sel = msqrt_pkg::SRC_XC; cmd_o.b_sel = msqrt_pkg::SRC_KK;
        cmd_o.dst = msqrt_pkg::DST_U;
        if (status_i.mul_done) state_d = ST_B3;
      end
      ST_B3: begin
        cmd_o.op = msqrt_pkg::OP_XC_SUMK;
        state_d  = ST_B4;
      end
      ST_B4: begin
        mul_req = 1'b1;
        cmd_o.a_sel = msqrt_pkg::SRC_CC; cmd_o.b_sel = msqrt_pkg::SRC_KK;
        cmd_o.dst = msqrt_pkg::DST_U;
        if (status_i.mul_done) state_d = ST_B5;
      end
      ST_B5: begin
        mul_req = 1'b1;
        cmd_o.a_sel = msqrt_pkg::SRC_T; cmd_o.b_sel = msqrt_pkg::SRC_N;
        cmd_o.dst = msqrt_pkg::DST_T;
        if (status_i.mul_done) state_d = ST_B6;
      end
      ST_B6: begin
        cmd_o.op = msqrt_pkg::OP_CC_SUM;
        state_d  = ST_C0;
      end
      ST_C0: state_d = status_i.cc_zero ? ST_R1 : ST_BTEST;
      ST_R1: begin
        mul_req = 1'b1;
        cmd_o.a_sel = msqrt_pkg::SRC_N; cmd_o.b_sel = msqrt_pkg::SRC_XC;
        cmd_o.dst = msqrt_pkg::DST_U;
        if (status_i.mul_done) state_d = ST_R2;
      end
      ST_R2: begin
        mul_req = 1'b1;
        cmd_o.a_sel = msqrt_pkg::SRC_U; cmd_o.b_sel = msqrt_pkg::SRC_U;
        cmd_o.dst = msqrt_pkg::DST_T;
        if (status_i.mul_done) state_d = ST_R3;
      end
      ST_R3: state_d = status_i.t_eq_n ? ST_OUTU : ST_BTEST;
      ST_OUTN: begin
        cmd_o.op = msqrt_pkg::OP_OUT_N;
        state_d  = ST_IDLE;
      end
      ST_OUTU: begin
        cmd_o.op = msqrt_pkg::OP_OUT_U;
        state_d  = ST_IDLE;
      end
      ST_OUTF: begin
        cmd_o.op = msqrt_pkg::OP_OUT_F;
        state_d  = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
    if (mul_req && !issued_q) begin
      cmd_o.op = msqrt_pkg::OP_MUL;
    end
    issued_d = mul_req && !status_i.mul_done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      issued_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      issued_q <= issued_d;
    end
  end

  assign busy = (state_q != ST_IDLE);

endmodule

[src/modular_square_root_prime.sv]
// top level of the modular square root block: sequencer plus datapath
// an item first reduces its value with one modular product, then goes on to the power or search products
// prime 3 mod 4: up to 60 products; otherwise up to 9 products per exponent bit per shift try
// one item at a time, the next start is taken in the cycle the result strobe shows
// every modular product goes through the one shared bit-serial modular multiplier
// asynchronous active-low reset returns the sequencer to idle and clears the strobe
module modular_square_root_prime (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  msqrt_pkg::in_t    in_i,
  output logic              busy,
  output msqrt_pkg::out_t   result_o,
  output logic              valid_o
);

  msqrt_pkg::cmd_t    cmd;
  msqrt_pkg::status_t status;

  msqrt_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .status_i(status),
    .cmd_o   (cmd),
    .busy    (busy)
  );

  msqrt_datapath u_datapath (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .cmd_i   (cmd),
    .status_o(status),
    .result_o(result_o),
    .valid_o (valid_o)
  );

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("accepted item did not raise busy");

  a_valid_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !busy) else $error("result strobe while still busy");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && result_o.failed) |-> (result_o.root == '0))
    else $error("failed result carries a nonzero root");

  a_busy_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start)) else $error("busy rose without start");

endmodule

[tb/msqrt_checker.sv]
// checker for the modular square root block: predicts each result and compares it
module msqrt_checker (
  input  logic            clk_i,
  input  logic            start,
  input  logic            busy,
  input  msqrt_pkg::in_t  in_i,
  input  msqrt_pkg::out_t result_o,
  input  logic            valid_o,
  output int              outstanding_o,
  output int              errors_o
);
  timeunit 1ns;
  timeprecision 1ps;

  msqrt_pkg::out_t roots_q[$];
  int              err_cnt = 0;

  function automatic logic [63:0] addm(logic [63:0] a, logic [63:0] b, logic [63:0] p);
    logic [63:0] s;
    s = a + b;
    if (s >= p) s = s - p;
    return s;
  endfunction

  function automatic logic [63:0] mulm(logic [63:0] a, logic [63:0] b, logic [63:0] p);
    logic [63:0] r;
    r = 0;
    for (int i = 63; i >= 0; i--) begin
      r = addm(r, r, p);
      if (b[i]) r = addm(r, a, p);
    end
    return r;
  endfunction

  function automatic logic [63:0] powm(logic [63:0] b, logic [63:0] e, logic [63:0] p);
    logic [63:0] r;
    r = 1 % p;
    while (e != 0) begin
      if (e[0]) r = mulm(r, b, p);
      b = mulm(b, b, p);
      e = e >> 1;
    end
    return r;
  endfunction

  function automatic msqrt_pkg::out_t predict_root(msqrt_pkg::in_t it);
    msqrt_pkg::out_t o;
    logic [63:0] v, p, n, mag, rem, half, top, kk, xc, cc, bitm, t, xy, r;
    o = '0;
    v = {32'b0, it.value};
    p = {33'b0, it.modulus};
    if (p == 0) begin
      o.failed = 1'b1;
      return o;
    end
    if (v[msqrt_pkg::VAL_W-1]) begin
      mag = (~v + 64'd1) & 64'hFFFF_FFFF;
      rem = mag % p;
      n = (rem == 0) ? 64'd0 : p - rem;
    end else begin
      n = v % p;
    end
    if (p == 2 || n == 0) begin
      o.root = n[msqrt_pkg::MOD_W-1:0];
      return o;
    end
    if (p[1:0] == 2'b11) begin
      r = powm(n, (p + 1) / 4, p);
      o.root = r[msqrt_pkg::MOD_W-1:0];
      return o;
    end
    half = (p - 1) / 2;
    top = 1;
    while (2 * top <= half) top = top * 2;
    for (int unsigned k = 1; (k / 2) < 64 && (64'd1 << (k / 2)) < p; k++) begin
      kk = 64'(k) % p;
      xc = 1 % p;
      cc = kk;
      bitm = top >> 1;
      while (bitm != 0) begin
        t = mulm(xc, xc, p);
        xy = mulm(xc, cc, p);
        xc = addm(xy, xy, p);
        cc = addm(mulm(cc, cc, p), mulm(t, n, p), p);
        if ((half & bitm) != 0) begin
          t = xc;
          xc = addm(cc, mulm(xc, kk, p), p);
          cc = addm(mulm(cc, kk, p), mulm(t, n, p), p);
        end
        if (cc == 0) begin
          r = mulm(n, xc, p);
          if (mulm(r, r, p) == n) begin
            o.root = r[msqrt_pkg::MOD_W-1:0];
            return o;
          end
        end
        bitm = bitm >> 1;
      end
    end
    o.failed = 1'b1;
    return o;
  endfunction

  assign errors_o      = err_cnt;
  assign outstanding_o = roots_q.size();

  always @(negedge clk_i) begin
    msqrt_pkg::out_t exp_r;
    int nerr;
    nerr = 0;
    if (valid_o) begin
      if (roots_q.size() == 0) begin
        $error("result with no item pending: root %0d failed %0b",
               result_o.root, result_o.failed);
        nerr = nerr + 1;
      end else begin
        exp_r = roots_q.pop_front();
        if (result_o.root !== exp_r.root) begin
          $error("root: expected %0d, actual %0d", exp_r.root, result_o.root);
          nerr = nerr + 1;
        end
        if (result_o.failed !== exp_r.failed) begin
          $error("failed: expected %0b, actual %0b", exp_r.failed, result_o.failed);
          nerr = nerr + 1;
        end
      end
    end
    if (start && !busy) roots_q.push_back(predict_root(in_i));
    err_cnt <= err_cnt + nerr;
  end

endmodule

[tb/tb.sv]
// testbench top for the modular square root block: stimulus, watchdog and verdict
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WATCHDOG = 2000000;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            start = 1'b0;
  msqrt_pkg::in_t  in_i = '0;
  logic            busy;
  msqrt_pkg::out_t result_o;
  logic            valid_o;
  int              outstanding;
  int              errors;
  int              idle_cycles = 0;
  logic [30:0]     big3[4] = '{31'd2147483647, 31'd2147483587, 31'd1000003, 31'd7};
  logic [30:0]     big1[5] = '{31'd2147483629, 31'd1000000009, 31'd65537, 31'd97, 31'd13};

  always #5 clk_i = ~clk_i;

  modular_square_root_prime u_top (
    .clk_i, .rst_ni, .start, .in_i, .busy, .result_o, .valid_o
  );

  msqrt_checker u_checker (
    .clk_i, .start, .busy, .in_i, .result_o, .valid_o,
    .outstanding_o(outstanding), .errors_o(errors)
  );

  always @(negedge clk_i) begin
    if ((start && !busy) || valid_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("** modular_square_root_prime: FAILED **");
      $finish;
    end
  end

  task automatic send_item(logic signed [31:0] v, logic [30:0] p);
    logic taken;
    start <= 1'b1;
    in_i <= '{value: v, modulus: p};
    do begin
      @(negedge clk_i);
      taken = !busy;
      @(posedge clk_i);
    end while (!taken);
  endtask

  task automatic pause_sender();
    int unsigned r, gap;
    r = $urandom_range(0, 99);
    if (r < 50) return;
    gap = (r < 90) ? $urandom_range(1, 3) : $urandom_range(10, 60);
    start <= 1'b0;
    repeat (gap) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    while (outstanding != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] square_of(logic [31:0] x, logic [30:0] p);
    logic [63:0] s;
    s = ({32'b0, x} % p) * ({32'b0, x} % p);
    s = s % {33'b0, p};
    return s[31:0];
  endfunction

  initial begin
    logic [30:0] p;
    logic [31:0] v;
    int unsigned pick;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // edge cases and special paths
    send_item(32'sd5, 31'd0);
    send_item(-32'sd7, 31'd1);
    send_item(32'sd3, 31'd2);
    send_item(-32'sd1, 31'd2);
    send_item(32'sd0, 31'd13);
    send_item(32'sd26, 31'd13);
    send_item(32'h8000_0000, 31'd7);
    send_item(32'h7FFF_FFFF, 31'h7FFF_FFFF);
    send_item(32'h8000_0000, 31'h7FFF_FFFF);
    send_item(32'sd4, 31'd3);
    send_item(32'sd3, 31'd4);
    send_item(32'sd4, 31'd4);
    send_item(32'sd4, 31'd15);
    send_item(32'sd9, 31'd21);
    send_item(32'sd6, 31'd12);
    send_item(32'sd2, 31'd13);
    send_item(32'sd10, 31'd13);
    send_item(-32'sd3, 31'd13);
    send_item(32'sd3, 31'd65537);
    send_item(32'sd2, 31'd2147483629);
    send_item(32'sd4, 31'd2147483629);
    send_item(-32'sd4, 31'd1000000009);
    send_item(32'h7FFF_FFFF, 31'd17);

    for (int i = 0; i < 200; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        p = 31'($urandom_range(0, 63));
        v = $urandom();
      end else if (pick < 60) begin
        p = big3[$urandom_range(0, 3)];
        v = $urandom();
      end else if (pick < 90) begin
        p = big1[$urandom_range(0, 4)];
        v = square_of($urandom(), p);
        if ($urandom_range(0, 1) == 1) v = -(32'(p) - v);
      end else begin
        p = big1[$urandom_range(2, 4)];
        v = $urandom();
      end
      pause_sender();
      send_item(v, p);
      if (i == 100) begin
        start <= 1'b0;
        wait_drained();
      end
    end
    start <= 1'b0;

    wait_drained();
    repeat (100) @(posedge clk_i);
    if (errors == 0 && outstanding == 0) begin
      $display("** modular_square_root_prime: PASSED **");
    end else begin
      $display("** modular_square_root_prime: FAILED **");
    end
    $finish;
  end

endmodule
